/* sv/pre_pkg.sv */
// Shared constants for the palette run-length pixel expander.
// No dependencies; used by the channel interfaces, the top level and its checker.
package pre_pkg;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 13;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CFG_W-1:0] COL_LIMIT    = CFG_W'(4096);
    localparam logic [CFG_W-1:0] CFG_RESET    = CFG_W'(64);
    localparam logic [ROW_W-1:0] ROW_MAX      = ROW_W'(8191);

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_RUN     = 1'b1;

    localparam logic REG_WIDTH   = 1'b0;
    localparam logic REG_HEIGHT  = 1'b1;

endpackage

/* sv/pre_ifs.sv */
// Valid/ready channel interfaces: request beats in, pixel beats out.
// Depends on pre_pkg for field widths.
interface pre_req_if;
    import pre_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [IDX_W-1:0]   palette_index;
    logic [COLOR_W-1:0] entry_color;
    logic [RUN_W-1:0]   run_length;

    modport source (output valid, req_type, palette_index, entry_color, run_length,
                    input ready);
    modport sink   (input valid, req_type, palette_index, entry_color, run_length,
                    output ready);
endinterface

interface pre_pix_if;
    import pre_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  pixel_col;
    logic [ROW_W-1:0]  pixel_row;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;
    logic              last_of_run;
    logic              out_of_range;

    modport source (output valid, pixel_col, pixel_row, blue_byte, green_byte, red_byte,
                    last_of_run, out_of_range, input ready);
    modport sink   (input valid, pixel_col, pixel_row, blue_byte, green_byte, red_byte,
                    last_of_run, out_of_range, output ready);
endinterface

/* sv/palette_rle_pixel_expander_unit.sv */
// Top level of the palette run-length pixel expander.
// Depends on pre_pkg and the channel interfaces in pre_ifs.sv.
//
// Usage:
//   req   : request beats. req_type REQ_PALETTE writes entry_color into the
//           palette at palette_index; REQ_RUN expands a run of run_length
//           pixels, clipped to MAX_RUN, of the palette color at palette_index.
//   pixel : one beat per pixel with column, row, color bytes, last-of-run
//           mark and out-of-range flag. Position advances in raster order.
//   APB   : image_width at byte address 0, image_height at 4; write only
//           while idle.
// Timing: a run holds req.ready low until its last pixel is loaded; the
//   accepting edge moves the state to ST_RUN, and the first pixel beat is
//   then loaded into the output register. One beat follows per cycle
//   while the output is not stalled, set by the single position advance
//   unit stepping once per pixel. A zero-length run gives no beat.
// Reset: palette reads black, position returns to column 0 row 0, width and
//   height return to 64. No clearing pass is needed.
// Stall: a held pixel beat stays in the output register and the run pauses
//   until pixel.ready returns.
module palette_rle_pixel_expander_unit #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_RUN       = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pre_req_if.sink                    req,
    pre_pix_if.source                  pixel,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pre_pkg::APB_AW-1:0] paddr,
    input  logic [pre_pkg::APB_DW-1:0] pwdata,
    output logic [pre_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pre_pkg::*;

    localparam int MEM_DEPTH = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [CFG_W-1:0]     width_reg, height_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [RUN_W-1:0]     remain_reg, remain_next;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic [COLOR_W-1:0]   palette_mem [MEM_DEPTH];

    logic                 out_valid_reg, out_valid_next;
    logic [COL_W-1:0]     out_col_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;
    logic                 out_oor_reg;

    logic                 req_fire;
    logic                 pal_we;
    logic                 run_start;
    logic                 load;
    logic [MEM_AW-1:0]    slot;
    logic [RUN_W-1:0]     run_len;
    logic [CFG_W-1:0]     eff_width;
    logic [CFG_W-1:0]     col_inc;
    logic [COLOR_W-1:0]   run_color;
    logic                 cfg_we;

    // map the palette index onto the palette depth through a constant table
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < (1 << IDX_W); i++)
        begin
            if (req.palette_index == IDX_W'(i))
            begin
                slot = MEM_AW'(i % PALETTE_DEPTH);
            end
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign pal_we    = req_fire && (req.req_type == REQ_PALETTE);
    assign run_len   = (req.run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : req.run_length;
    assign run_start = req_fire && (req.req_type == REQ_RUN);
    assign load      = (state_reg == ST_RUN) && (!out_valid_reg || pixel.ready);
    assign run_color = rd_valid_reg ? rd_data_reg : '0;

    // position advance unit
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = CFG_W'(1);
        end
        else if (width_reg > COL_LIMIT)
        begin
            eff_width = COL_LIMIT;
        end
        else
        begin
            eff_width = width_reg;
        end
        col_inc  = CFG_W'(col_reg) + CFG_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (load)
        begin
            if (col_inc >= eff_width)
            begin
                col_next = '0;
                if (row_reg < ROW_MAX)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_start && (run_len != '0))
                begin
                    state_next  = ST_RUN;
                    remain_next = run_len;
                end
            end
            ST_RUN:
            begin
                if (load)
                begin
                    remain_next = remain_reg - RUN_W'(1);
                    if (remain_reg == RUN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= CFG_RESET;
            height_reg    <= CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (pal_we)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (run_start)
            begin
                rd_valid_reg <= valid_reg[slot];
            end
            if (cfg_we)
            begin
                if (paddr[2] == REG_WIDTH)
                begin
                    width_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    height_reg <= pwdata[CFG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            palette_mem[slot] <= req.entry_color;
        end
        if (run_start)
        begin
            rd_data_reg <= palette_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_color_reg <= run_color;
            out_last_reg  <= (remain_reg == RUN_W'(1));
            out_oor_reg   <= (CFG_W'(row_reg) >= height_reg);
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_col    = out_col_reg;
    assign pixel.pixel_row    = out_row_reg;
    assign pixel.blue_byte    = out_color_reg[BYTE_W-1:0];
    assign pixel.green_byte   = out_color_reg[2*BYTE_W-1:BYTE_W];
    assign pixel.red_byte     = out_color_reg[3*BYTE_W-1:2*BYTE_W];
    assign pixel.last_of_run  = out_last_reg;
    assign pixel.out_of_range = out_oor_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

endmodule

/* sv/pre_checker.sv */
// Port-level checker for the palette run-length pixel expander, with its bind.
// Depends on pre_pkg and the top level palette_rle_pixel_expander_unit.
module pre_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_type,
    input logic [pre_pkg::RUN_W-1:0]    req_len,
    input logic                         pix_valid,
    input logic                         pix_ready,
    input logic [pre_pkg::COL_W-1:0]    pix_col,
    input logic [pre_pkg::ROW_W-1:0]    pix_row,
    input logic                         pix_last
);
    import pre_pkg::*;

    // hold a stalled pixel beat
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_col) && $stable(pix_row))
        else $error("stalled pixel beat changed");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_RUN) && (req_len != '0) |=> !req_ready)
        else $error("request taken while a run was pending");

    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_last |-> !req_ready)
        else $error("request side open in the middle of a run");

    a_run_streams: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix_last |=> pix_valid)
        else $error("gap inside a run");

endmodule

bind palette_rle_pixel_expander_unit pre_checker u_pre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .req_len   (req.run_length),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .pix_col   (pixel.pixel_col),
    .pix_row   (pixel.pixel_row),
    .pix_last  (pixel.last_of_run)
);

/* verif/palette_rle_pixel_expander_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for palette_rle_pixel_expander_unit: random and directed
// palette writes and runs, predicted pixel beats checked in order.
// Depends on pre_pkg, the channel interfaces in pre_ifs.sv and the top level.
module palette_rle_pixel_expander_unit_tb;
    import pre_pkg::*;

    localparam int PAL_DEPTH  = 256;
    localparam int RUN_CAP    = 64;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   run_len;
    } req_beat_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic              last;
        logic              oor;
    } pixel_beat_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pre_req_if req_ch();
    pre_pix_if pix_ch();

    palette_rle_pixel_expander_unit #(
        .PALETTE_DEPTH(PAL_DEPTH),
        .MAX_RUN      (RUN_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch.sink),
        .pixel  (pix_ch.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #1 clk = ~clk;

    logic [COLOR_W-1:0] pal_colors [PAL_DEPTH];
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [CFG_W-1:0]   cfg_width;
    logic [CFG_W-1:0]   cfg_height;

    req_beat_t   pending_requests[$];
    pixel_beat_t expected_pixels[$];
    int unsigned error_count = 0;
    int unsigned src_idle_pct = 15;
    int unsigned snk_idle_pct = 15;
    int unsigned quiet_cycles = 0;

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic add_request(req_beat_t b);
        pending_requests.insert(pending_requests.size(), b);
    endtask

    task automatic add_pixel(pixel_beat_t p);
        expected_pixels.insert(expected_pixels.size(), p);
    endtask

    task automatic expand_request(req_beat_t b);
        pixel_beat_t      p;
        logic [COLOR_W-1:0] c;
        int               n;
        int               eff;
        if (b.kind == REQ_PALETTE)
        begin
            pal_colors[b.index] = b.color;
            return;
        end
        n = (b.run_len > RUN_CAP) ? RUN_CAP : int'(b.run_len);
        c = pal_colors[b.index];
        if (cfg_width == '0)
            eff = 1;
        else if (cfg_width > COL_LIMIT)
            eff = int'(COL_LIMIT);
        else
            eff = int'(cfg_width);
        for (int k = 0; k < n; k++)
        begin
            p.col   = cur_col;
            p.row   = cur_row;
            p.blue  = c[7:0];
            p.green = c[15:8];
            p.red   = c[23:16];
            p.last  = (k == n - 1);
            p.oor   = (cur_row >= cfg_height);
            add_pixel(p);
            if (int'(cur_col) + 1 >= eff)
            begin
                cur_col = '0;
                if (cur_row < ROW_MAX)
                    cur_row = cur_row + 1'b1;
            end
            else
            begin
                cur_col = cur_col + 1'b1;
            end
        end
    endtask

    function automatic req_beat_t make_request(logic kind, int unsigned idx,
                                               int unsigned color, int unsigned len);
        req_beat_t b;
        b.kind    = kind;
        b.index   = IDX_W'(idx);
        b.color   = COLOR_W'(color);
        b.run_len = RUN_W'(len);
        return b;
    endfunction

    function automatic req_beat_t random_request();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 55)
            len = $urandom_range(8);
        else if (pick < 85)
            len = $urandom_range(63, 9);
        else if (pick < 93)
            len = RUN_CAP;
        else
            len = $urandom_range(127, 65);
        return make_request(($urandom_range(99) < 30) ? REQ_PALETTE : REQ_RUN,
                            $urandom_range(255), $urandom(), len);
    endfunction

    task automatic apb_write(logic reg_sel, int unsigned value);
        logic [APB_DW-1:0] word;
        word = {(APB_DW-CFG_W)'($urandom()), CFG_W'(value)};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_WIDTH)
            cfg_width = word[CFG_W-1:0];
        else
            cfg_height = word[CFG_W-1:0];
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_pixels.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned n_items);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, (h > 8191) ? 8191 : h);
        repeat (n_items) add_request(random_request());
        wait_drained();
    endtask

    // driver: hold the beat until accepted, then advance
    always @(posedge clk)
    begin
        req_beat_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expand_request(req_beat_t'{req_ch.req_type, req_ch.palette_index,
                                           req_ch.entry_color, req_ch.run_length});
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = pending_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= nxt.kind;
                    req_ch.palette_index <= nxt.index;
                    req_ch.entry_color   <= nxt.color;
                    req_ch.run_length    <= nxt.run_len;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each pixel beat with the oldest prediction
    always @(posedge clk)
    begin
        pixel_beat_t got;
        pixel_beat_t want;
        if (!rst_n)
        begin
            pix_ch.ready <= 1'b0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                got = '{pix_ch.pixel_col, pix_ch.pixel_row, pix_ch.blue_byte,
                        pix_ch.green_byte, pix_ch.red_byte, pix_ch.last_of_run,
                        pix_ch.out_of_range};
                if (expected_pixels.size() == 0)
                begin
                    report_error($sformatf("unexpected pixel beat col %0d row %0d",
                                           got.col, got.row));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_col", got.col, want.col);
                    check_field("pixel_row", got.row, want.row);
                    check_field("blue_byte", got.blue, want.blue);
                    check_field("green_byte", got.green, want.green);
                    check_field("red_byte", got.red, want.red);
                    check_field("last_of_run", got.last, want.last);
                    check_field("out_of_range", got.oor, want.oor);
                end
            end
            pix_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n_sat;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_PALETTE;
        req_ch.palette_index = '0;
        req_ch.entry_color   = '0;
        req_ch.run_length    = '0;
        pix_ch.ready         = 1'b0;
        foreach (pal_colors[i]) pal_colors[i] = '0;
        cur_col    = '0;
        cur_row    = '0;
        cfg_width  = CFG_RESET;
        cfg_height = CFG_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset palette is black, then extremes, empty and clipped runs
        add_request(make_request(REQ_RUN, 0, 24'hFFFFFF, 3));
        add_request(make_request(REQ_PALETTE, 0, 24'hFFFFFF, 127));
        add_request(make_request(REQ_PALETTE, 255, 24'h0000FF, 0));
        add_request(make_request(REQ_PALETTE, 128, 24'hFF0000, 64));
        add_request(make_request(REQ_PALETTE, 1, 24'h00FF00, 1));
        add_request(make_request(REQ_RUN, 0, 0, 1));
        add_request(make_request(REQ_RUN, 255, 0, 0));
        add_request(make_request(REQ_RUN, 255, 24'hFFFFFF, 64));
        add_request(make_request(REQ_RUN, 128, 0, 127));
        add_request(make_request(REQ_RUN, 1, 0, 65));
        add_request(make_request(REQ_PALETTE, 0, 24'h000000, 0));
        add_request(make_request(REQ_RUN, 0, 0, 2));
        add_request(make_request(REQ_RUN, 77, 0, 60));
        add_request(make_request(REQ_PALETTE, 170, 24'hA5A5A5, 85));
        add_request(make_request(REQ_PALETTE, 85, 24'h5A5A5A, 42));
        add_request(make_request(REQ_RUN, 170, 0, 1));
        add_request(make_request(REQ_RUN, 85, 0, 1));
        add_request(make_request(REQ_RUN, 255, 24'hFFFFFF, 0));
        wait_drained();

        run_phase(1, 1, 35);
        run_phase(4096, 4096, 35);
        run_phase(0, 0, 30);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(8191, 8191, 30);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        run_phase(200, cur_row + 3, 35);
        run_phase(3, cur_row + 20, 35);
        run_phase($urandom_range(80, 1), cur_row + $urandom_range(40), 35);
        run_phase($urandom_range(80, 1), cur_row + $urandom_range(40), 35);

        // drive the row into saturation with full runs
        apb_write(REG_WIDTH, 1);
        apb_write(REG_HEIGHT, 4096);
        n_sat = (ROW_MAX - cur_row) / RUN_CAP + 4;
        repeat (n_sat)
            add_request(make_request(REQ_RUN, $urandom_range(255), $urandom(), RUN_CAP));
        wait_drained();
        run_phase(64, 8191, 10);

        repeat (70) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_error($sformatf("%0d pixel beats never arrived", expected_pixels.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/pre_pkg.sv
sv/pre_ifs.sv
sv/palette_rle_pixel_expander_unit.sv
sv/pre_checker.sv
verif/palette_rle_pixel_expander_unit_tb.sv
